// ===== rtl/core/fhst_pkg.sv =====
// ----------------------------------------------------------------------------
// fhst_pkg: shared types and constants
// SHA-256 round constants, initial hash value and controller command struct.
// ----------------------------------------------------------------------------
package fhst_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned BlockW = 512;
	localparam int unsigned DigestW = 256;
	localparam int unsigned TagW = 32;
	localparam int unsigned RoundW = 6;

	// block select codes for the datapath block mux
	localparam logic [1:0] BLK_IPAD = 2'd0;
	localparam logic [1:0] BLK_MSG = 2'd1;
	localparam logic [1:0] BLK_OPAD = 2'd2;
	localparam logic [1:0] BLK_INNER = 2'd3;

	typedef struct packed {
		logic       load_msg;   // capture the packed message
		logic       start;      // load block into schedule, working vars
		logic       init_h;     // chaining value starts from the IV
		logic [1:0] blk_sel;
		logic       round;      // run one round
		logic       finish;     // add working vars into chaining value
		logic       save_inner; // keep inner digest
	} fhst_cmd_t;

	function automatic logic [WordW-1:0] round_k(input logic [RoundW-1:0] i);
		logic [WordW-1:0] k;
		unique case (i)
			6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
			6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
			6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
			6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
			6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
			6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
			6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
			6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
			6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
			6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
			6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
			6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
			6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
			6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
			6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
			6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
			6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
			6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
			6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
			6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
			6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
			default: k = 32'hc67178f2;
		endcase
		return k;
	endfunction

	localparam logic [DigestW-1:0] IV = {
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

endpackage

// ===== rtl/core/fhst_ctrl.sv =====
// ----------------------------------------------------------------------------
// fhst_ctrl: HMAC sequencer
// Steps four SHA-256 compressions of 64 rounds each and runs the handshakes.
// ----------------------------------------------------------------------------
module fhst_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output fhst_pkg::fhst_cmd_t cmd,
	output logic [5:0]          round_idx
);
	import fhst_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_START = 2'd1;
	localparam logic [1:0] ST_ROUND = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0] state_q;
	logic [1:0] blk_q;
	logic [5:0] rnd_q;
	logic       out_valid_q;

	// next item may enter once the previous tag has left the output register
	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign out_valid = out_valid_q;
	assign round_idx = rnd_q;

	always_comb begin
		cmd = '0;
		cmd.blk_sel = blk_q;
		cmd.load_msg = in_valid && in_ready;
		cmd.start = (state_q == ST_START);
		cmd.init_h = (blk_q == BLK_IPAD) || (blk_q == BLK_OPAD);
		cmd.round = (state_q == ST_ROUND);
		cmd.finish = (state_q == ST_DONE);
		cmd.save_inner = (state_q == ST_DONE) && (blk_q == BLK_MSG);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			blk_q <= BLK_IPAD;
			rnd_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						blk_q <= BLK_IPAD;
						state_q <= ST_START;
					end
				end
				ST_START: begin
					rnd_q <= '0;
					state_q <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63)
						state_q <= ST_DONE;
				end
				default: begin
					if (blk_q == BLK_INNER) begin
						out_valid_q <= 1'b1;
						state_q <= ST_IDLE;
					end else begin
						blk_q <= blk_q + 2'd1;
						state_q <= ST_START;
					end
				end
			endcase
		end
	end

endmodule

// ===== rtl/core/fhst_dp.sv =====
// ----------------------------------------------------------------------------
// fhst_dp: SHA-256 datapath
// Message packing, block select, 16-word schedule window and one round a cycle.
// ----------------------------------------------------------------------------
module fhst_dp #(
	parameter int unsigned KEY_BYTES = 64,
	parameter int unsigned ID_BYTES = 6
) (
	input  logic                clk,
	input  fhst_pkg::fhst_cmd_t cmd,
	input  logic [5:0]          round_idx,
	input  logic [511:0]        key,
	input  logic [7:0]          version_byte,
	input  logic [7:0]          kind_byte,
	input  logic [7:0]          event_kind,
	input  logic [7:0]          flag_bits,
	input  logic [47:0]         origin_bytes,
	input  logic [31:0]         event_number,
	input  logic [15:0]         attempt_number,
	input  logic [7:0]          hop_limit,
	input  logic [31:0]         event_time,
	input  logic signed [31:0]  latitude,
	input  logic signed [31:0]  longitude,
	input  logic [7:0]          battery_level,
	output logic [31:0]         tag_word
);
	import fhst_pkg::*;

	localparam int unsigned MsgBytes = 24 + ID_BYTES;
	localparam int unsigned MsgW = 8 * MsgBytes;
	localparam int unsigned PadW = BlockW - MsgW - 64;
	localparam logic [63:0] MsgBits = 64'((64 + MsgBytes) * 8);
	localparam logic [63:0] InnerBits = 64'((64 + 32) * 8);

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [31:0] bswap(input logic [31:0] x);
		return {x[7:0], x[15:8], x[23:16], x[31:24]};
	endfunction

	logic [MsgW-1:0]    msg_q;
	logic [511:0]       kmask;
	logic [511:0]       blk;
	logic [31:0]        w_q [16];
	logic [31:0]        v_q [8];
	logic [31:0]        h_q [8];
	logic [DigestW-1:0] inner_q;
	logic [63:0]        id_ext;

	// id bytes in order, first byte in msb of the low ID_BYTES bytes
	assign id_ext = 64'(origin_bytes);

	always_ff @(posedge clk) begin
		if (cmd.load_msg)
			msg_q <= {version_byte, kind_byte, event_kind, flag_bits,
				id_ext[8 * ID_BYTES - 1:0], bswap(event_number),
				attempt_number[7:0], attempt_number[15:8], hop_limit,
				bswap(event_time), bswap(latitude), bswap(longitude),
				battery_level};
	end

	always_comb begin
		for (int i = 0; i < 64; i++)
			kmask[511 - 8 * i -: 8] = (i < KEY_BYTES) ? key[511 - 8 * i -: 8] : 8'h00;
	end

	always_comb begin
		unique case (cmd.blk_sel)
			BLK_IPAD: blk = kmask ^ {64{8'h36}};
			BLK_MSG: blk = {msg_q, 8'h80, {(PadW - 8){1'b0}}, MsgBits};
			BLK_OPAD: blk = kmask ^ {64{8'h5c}};
			default: blk = {inner_q, 8'h80, {(BlockW - DigestW - 72){1'b0}}, InnerBits};
		endcase
	end

	logic [31:0] s0, s1, w_new, e1, ch, a0, mj, t1, t2;

	always_comb begin
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		w_new = w_q[0] + s0 + w_q[9] + s1;
		e1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + e1 + ch + round_k(round_idx) + w_q[0];
		a0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		mj = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = a0 + mj;
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			for (int i = 0; i < 16; i++)
				w_q[i] <= blk[511 - 32 * i -: 32];
			for (int i = 0; i < 8; i++) begin
				if (cmd.init_h) begin
					v_q[i] <= IV[255 - 32 * i -: 32];
					h_q[i] <= IV[255 - 32 * i -: 32];
				end else begin
					v_q[i] <= h_q[i];
				end
			end
		end else if (cmd.round) begin
			for (int i = 0; i < 15; i++)
				w_q[i] <= w_q[i + 1];
			w_q[15] <= w_new;
			v_q[0] <= t1 + t2;
			v_q[1] <= v_q[0];
			v_q[2] <= v_q[1];
			v_q[3] <= v_q[2];
			v_q[4] <= v_q[3] + t1;
			v_q[5] <= v_q[4];
			v_q[6] <= v_q[5];
			v_q[7] <= v_q[6];
		end else if (cmd.finish) begin
			for (int i = 0; i < 8; i++)
				h_q[i] <= h_q[i] + v_q[i];
		end
		if (cmd.save_inner) begin
			for (int i = 0; i < 8; i++)
				inner_q[255 - 32 * i -: 32] <= h_q[i] + v_q[i];
		end
	end

	// digest bytes 0..3 are h0 big-endian; tag puts byte 0 lowest
	assign tag_word = bswap(h_q[0]);

endmodule

// ===== rtl/core/frame_hmac_sha256_tag.sv =====
// ----------------------------------------------------------------------------
// frame_hmac_sha256_tag: truncated HMAC-SHA256 frame tag
// Packs frame fields into a message and returns the first four digest bytes.
// ----------------------------------------------------------------------------
// One item runs four SHA-256 compressions between transfer and tag valid
// (ipad block, message block, opad block, inner digest block), each a
// load, 64 rounds through the single round unit and one chaining add. The
// round unit is the bottleneck; the next item is taken once the tag has
// been transferred out. The user writes key registers only while the block
// is idle; the block does not enforce it. Key indexes run 0 to 7.
module frame_hmac_sha256_tag #(
	parameter int unsigned KEY_BYTES = 64,
	parameter int unsigned ID_BYTES = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [63:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         version_byte,
	input  logic [7:0]         kind_byte,
	input  logic [7:0]         event_kind,
	input  logic [7:0]         flag_bits,
	input  logic [47:0]        origin_bytes,
	input  logic [31:0]        event_number,
	input  logic [15:0]        attempt_number,
	input  logic [7:0]         hop_limit,
	input  logic [31:0]        event_time,
	input  logic signed [31:0] latitude,
	input  logic signed [31:0] longitude,
	input  logic [7:0]         battery_level,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        tag_word
);
	import fhst_pkg::*;

	fhst_cmd_t   cmd;
	logic [5:0]  round_idx;
	logic [63:0] key_q [8];
	logic [511:0] key;

	// key registers, byte 0 of the key in the msbs of word 0
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 8; i++)
				key_q[i] <= '0;
		end else if (cfg_valid) begin
			key_q[cfg_index] <= cfg_data;
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++)
			key[511 - 64 * i -: 64] = key_q[i];
	end

	fhst_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.round_idx (round_idx)
	);

	fhst_dp #(
		.KEY_BYTES (KEY_BYTES),
		.ID_BYTES  (ID_BYTES)
	) u_dp (
		.clk            (clk),
		.cmd            (cmd),
		.round_idx      (round_idx),
		.key            (key),
		.version_byte   (version_byte),
		.kind_byte      (kind_byte),
		.event_kind     (event_kind),
		.flag_bits      (flag_bits),
		.origin_bytes   (origin_bytes),
		.event_number   (event_number),
		.attempt_number (attempt_number),
		.hop_limit      (hop_limit),
		.event_time     (event_time),
		.latitude       (latitude),
		.longitude      (longitude),
		.battery_level  (battery_level),
		.tag_word       (tag_word)
	);

	// no new item while a tag waits
	assert property (@(posedge clk) disable iff (!arst_n) out_valid |-> !in_ready)
		else $error("input taken while tag pending");
	// a finished tag stays put until transferred
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(tag_word))
		else $error("tag lost before transfer");
	// round command only ever in the round phase, never with a load
	assert property (@(posedge clk) disable iff (!arst_n) !(cmd.round && cmd.start))
		else $error("round and load overlap");

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: frame tag testbench
// Drives frame fields and key writes, predicts each truncated HMAC-SHA256 tag
// and checks tags in order against a queue of expected values.
// ----------------------------------------------------------------------------
module tb_top;
	import fhst_pkg::*;

	localparam int ItemLatency = 300;
	localparam longint CycleLimit = 5000000;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;
	logic in_valid;
	logic in_ready;
	logic [7:0] version_byte, kind_byte, event_kind, flag_bits, hop_limit, battery_level;
	logic [47:0] origin_bytes;
	logic [31:0] event_number, event_time;
	logic [15:0] attempt_number;
	logic signed [31:0] latitude, longitude;
	logic out_valid;
	logic out_ready;
	logic [31:0] tag_word;

	typedef struct {
		logic [7:0] version, kind, evkind, flags, hops, battery;
		logic [47:0] origin;
		logic [31:0] evnum, evtime, lat, lon;
		logic [15:0] attempt;
	} frame_t;

	logic [63:0] key_regs [8];
	logic [31:0] tag_queue [$];
	int errors;
	longint cycles;
	bit hold_off;   // long receiver stall requested
	bit stall_all;  // receiver always ready when set

	frame_hmac_sha256_tag dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------- predictor ----------------
	function automatic logic [31:0] rotr(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	function automatic logic [255:0] sha_block(logic [255:0] hin, logic [511:0] blk);
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2, ch, mj;
		logic [255:0] hout;
		for (int i = 0; i < 16; i++) w[i] = blk[511 - 32*i -: 32];
		for (int i = 16; i < 64; i++) begin
			s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++) v[i] = hin[255 - 32*i -: 32];
		for (int i = 0; i < 64; i++) begin
			ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
			t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25)) + ch
				+ round_k(i[5:0]) + w[i];
			mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22)) + mj;
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) hout[255 - 32*i -: 32] = hin[255 - 32*i -: 32] + v[i];
		return hout;
	endfunction

	// key block xored with pad, then one data block of len bytes (MSB-first)
	function automatic logic [255:0] keyed_digest(logic [7:0] pad, logic [511:0] data, int len);
		logic [511:0] kblk, mblk;
		logic [255:0] h;
		logic [63:0] bits;
		for (int i = 0; i < 64; i++) kblk[511 - 8*i -: 8] = key_regs[i/8][63 - 8*(i%8) -: 8] ^ pad;
		h = sha_block(IV, kblk);
		mblk = data;
		mblk[511 - 8*len -: 8] = 8'h80;
		bits = 64'((64 + len) * 8);
		mblk[63:0] = bits;
		return sha_block(h, mblk);
	endfunction

	function automatic logic [31:0] frame_tag(frame_t f);
		logic [511:0] m;
		logic [255:0] inner, outer;
		logic [239:0] msg;
		m = '0;
		msg = {f.version, f.kind, f.evkind, f.flags, f.origin,
			{<<8{f.evnum}}, {<<8{f.attempt}}, f.hops, {<<8{f.evtime}},
			{<<8{f.lat}}, {<<8{f.lon}}, f.battery};
		m[511 -: 240] = msg;
		inner = keyed_digest(8'h36, m, 30);
		m = '0;
		m[511 -: 256] = inner;
		outer = keyed_digest(8'h5c, m, 32);
		return {outer[231:224], outer[239:232], outer[247:240], outer[255:248]};
	endfunction

	// ---------------- drivers ----------------
	task automatic idle_gap();
		int n;
		n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(0, 3);
		if ($urandom_range(0, 3) == 0) n = 0;
		repeat (n) @(posedge clk);
	endtask

	task automatic send_frame(frame_t f);
		idle_gap();
		version_byte <= f.version; kind_byte <= f.kind; event_kind <= f.evkind;
		flag_bits <= f.flags; origin_bytes <= f.origin; event_number <= f.evnum;
		attempt_number <= f.attempt; hop_limit <= f.hops; event_time <= f.evtime;
		latitude <= f.lat; longitude <= f.lon; battery_level <= f.battery;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		tag_queue.push_back(frame_tag(f));
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic drain();
		while (tag_queue.size() != 0) @(posedge clk);
		repeat (ItemLatency) @(posedge clk);
	endtask

	task automatic write_key(logic [2:0] idx, logic [63:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		key_regs[idx] = val;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic frame_t random_frame();
		frame_t f;
		f.version = 8'($urandom); f.kind = 8'($urandom); f.evkind = 8'($urandom);
		f.flags = 8'($urandom);
		f.origin = 48'({$urandom, $urandom}); f.evnum = $urandom;
		f.attempt = 16'($urandom);
		f.hops = 8'($urandom); f.evtime = $urandom; f.lat = $urandom; f.lon = $urandom;
		f.battery = 8'($urandom);
		return f;
	endfunction

	function automatic frame_t fill_frame(logic [7:0] b);
		frame_t f;
		f.version = b; f.kind = b; f.evkind = b; f.flags = b; f.hops = b; f.battery = b;
		f.origin = {6{b}}; f.evnum = {4{b}}; f.attempt = {2{b}}; f.evtime = {4{b}};
		f.lat = {4{b}}; f.lon = {4{b}};
		return f;
	endfunction

	// ---------------- tag checker ----------------
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (tag_queue.size() == 0) begin
				$display("%0t unexpected tag: actual %h", $time, tag_word);
				errors++;
			end else begin
				if (tag_word !== tag_queue[0]) begin
					$display("%0t tag mismatch: expected %h actual %h",
						$time, tag_queue[0], tag_word);
					errors++;
				end
				void'(tag_queue.pop_front());
			end
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	always @(posedge clk) begin
		if (hold_off) begin
			out_ready <= 1'b0;
			repeat (2000) @(posedge clk);
			hold_off = 1'b0;
		end else if (stall_all) out_ready <= 1'b1;
		else if ($urandom_range(0, 19) == 0) begin
			out_ready <= 1'b0;
			repeat ($urandom_range(20, 300)) @(posedge clk);
		end else out_ready <= ($urandom_range(0, 3) != 0);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// ---------------- tests ----------------
	task automatic test_reset_key();
		frame_t f;
		f = fill_frame(8'h00); send_frame(f);
		f = fill_frame(8'hff); send_frame(f);
		drain();
	endtask

	task automatic test_field_extremes();
		frame_t f;
		// all-ones key, then all-zero and all-ones frames, then checkered patterns
		for (int i = 0; i < 8; i++) write_key(i[2:0], '1);
		f = fill_frame(8'h00); send_frame(f);
		f = fill_frame(8'hff); send_frame(f);
		f = fill_frame(8'h55); send_frame(f);
		f = fill_frame(8'haa); send_frame(f);
		// signed coordinates at their limits
		f = random_frame(); f.lat = 32'h80000000; f.lon = 32'h7fffffff; send_frame(f);
		f = random_frame(); f.lat = 32'h7fffffff; f.lon = 32'h80000000; send_frame(f);
		f = random_frame(); f.lat = '1; f.lon = 32'd0; send_frame(f);
		drain();
		// short key: only the first bytes nonzero
		write_key(3'd0, 64'h0102030405060708);
		for (int i = 1; i < 8; i++) write_key(i[2:0], '0);
		f = random_frame(); send_frame(f);
		drain();
		// only the last key byte set
		write_key(3'd0, '0);
		write_key(3'd7, 64'h00000000000000ff);
		f = random_frame(); send_frame(f);
		drain();
	endtask

	task automatic test_random_frames(int count);
		for (int k = 0; k < count; k++) begin
			if (k % 200 == 0) begin
				drain();
				for (int i = 0; i < 8; i++)
					write_key(i[2:0], ($urandom_range(0, 2) == 0) ? 64'd0
						: {$urandom, $urandom});
			end
			send_frame(random_frame());
		end
		drain();
	endtask

	task automatic test_backpressure();
		// receiver holds off while frames keep coming; block must stall input
		hold_off = 1'b1;
		for (int k = 0; k < 6; k++) send_frame(random_frame());
		drain();
		// receiver always ready
		stall_all = 1'b1;
		for (int k = 0; k < 10; k++)
			send_frame(random_frame());
		drain();
		stall_all = 1'b0;
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		in_valid = 1'b0;
		version_byte = '0; kind_byte = '0; event_kind = '0; flag_bits = '0;
		origin_bytes = '0; event_number = '0; attempt_number = '0; hop_limit = '0;
		event_time = '0; latitude = '0; longitude = '0; battery_level = '0;
		out_ready = 1'b0;
		errors = 0; cycles = 0; hold_off = 1'b0; stall_all = 1'b0;
		for (int i = 0; i < 8; i++) key_regs[i] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_key();
		test_field_extremes();
		test_backpressure();
		test_random_frames(820);
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/fhst_pkg.sv
rtl/core/fhst_ctrl.sv
rtl/core/fhst_dp.sv
rtl/core/frame_hmac_sha256_tag.sv
test/tb_top.sv
